// File: rtl/matrix4_vector_transform_assert.svh
// assertion macros shared by the checker
`ifndef MATRIX4_VECTOR_TRANSFORM_ASSERT_SVH
`define MATRIX4_VECTOR_TRANSFORM_ASSERT_SVH

// same-cycle implication, off while reset is high
`define MVT_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define MVT_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

// next-cycle implication that also covers reset itself
`define MVT_ASSERT_NEXT_ALWAYS(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: rtl/mvt_pkg.sv
package mvt_pkg;

   // coefficient and result word width, 16 to 32
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int PORT_BITS = 32;
   localparam int LANES     = 4;
   localparam int IDX_BITS  = 2;

   // vector operands must also hold 1.0 for the position mode
   localparam int VEC_BITS  = (WORD_BITS < 18) ? 18 : WORD_BITS;
   localparam int PROD_BITS = WORD_BITS + VEC_BITS;
   localparam int SUM_BITS  = PROD_BITS + 2;

   localparam logic [2:0] CMD_LOAD = 3'd0;
   localparam logic [2:0] CMD_VXM  = 3'd1;
   localparam logic [2:0] CMD_MXV  = 3'd2;
   localparam logic [2:0] CMD_POS  = 3'd3;
   localparam logic [2:0] CMD_DIR  = 3'd4;

   localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   // 1.0 saturated to the word range
   localparam logic [WORD_BITS-1:0] COEF_ONE =
      (WORD_BITS > 17) ? WORD_BITS'(32'd65536) : WORD_MAX;
   localparam logic [VEC_BITS-1:0] VEC_ONE = VEC_BITS'(32'd65536);

   typedef struct packed {
      logic [2:0]                  cmd;
      logic [1:0]                  row_index;
      logic [1:0]                  col_index;
      logic signed [PORT_BITS-1:0] vec_x;
      logic signed [PORT_BITS-1:0] vec_y;
      logic signed [PORT_BITS-1:0] vec_z;
      logic signed [PORT_BITS-1:0] vec_w;
   } req_type;

   typedef struct packed {
      logic signed [PORT_BITS-1:0] res_x;
      logic signed [PORT_BITS-1:0] res_y;
      logic signed [PORT_BITS-1:0] res_z;
      logic signed [PORT_BITS-1:0] res_w;
   } rsp_type;

   // what travels from cell to cell
   typedef struct packed {
      logic                                is_load;
      logic                                col_mode;
      logic                                zero_w;
      logic [IDX_BITS-1:0]                 row;
      logic [IDX_BITS-1:0]                 col;
      logic [LANES-1:0][VEC_BITS-1:0]      vec;
      logic [LANES-1:0][SUM_BITS-1:0]      sums;
   } beat_type;

endpackage

// File: rtl/mvt_cell.sv
module mvt_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mvt_pkg::IDX_BITS-1:0]  cell_index,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  mvt_pkg::beat_type             in_beat,
   output logic                          out_valid,
   input  logic                          out_ready,
   output mvt_pkg::beat_type             out_beat
);

   // row cell_index and column cell_index of the matrix
   logic [mvt_pkg::LANES-1:0][mvt_pkg::WORD_BITS-1:0] row_ff, row_in;
   logic [mvt_pkg::LANES-1:0][mvt_pkg::WORD_BITS-1:0] col_ff, col_in;
   logic [mvt_pkg::LANES-1:0][mvt_pkg::WORD_BITS-1:0] ident;
   logic [mvt_pkg::LANES-1:0][mvt_pkg::WORD_BITS-1:0] coef_sel;

   logic                                   a_valid_ff, b_valid_ff;
   mvt_pkg::beat_type                      a_beat_ff, b_beat_ff, b_beat_in;
   logic signed [mvt_pkg::PROD_BITS-1:0]   prod_ff [mvt_pkg::LANES];
   logic signed [mvt_pkg::PROD_BITS-1:0]   prod_in [mvt_pkg::LANES];
   logic signed [mvt_pkg::SUM_BITS-1:0]    prod_ext [mvt_pkg::LANES];
   logic signed [mvt_pkg::VEC_BITS-1:0]    operand;
   logic [mvt_pkg::WORD_BITS-1:0]          load_word;
   logic                                   a_ready, b_ready, take;

   always_comb begin
      b_ready = !b_valid_ff || out_ready;
      a_ready = !a_valid_ff || b_ready;
      take    = in_valid && a_ready;
   end

   assign in_ready  = a_ready;
   assign out_valid = b_valid_ff;
   assign out_beat  = b_beat_ff;

   always_comb begin
      for (int j = 0; j < mvt_pkg::LANES; j++) begin
         ident[j] = (mvt_pkg::IDX_BITS'(j) == cell_index) ? mvt_pkg::COEF_ONE : '0;
      end
   end

   // a load writes the element where its row or column meets this cell
   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      load_word = in_beat.vec[0][mvt_pkg::WORD_BITS-1:0];
      if (take && in_beat.is_load) begin
         if (in_beat.row == cell_index) begin
            row_in[in_beat.col] = load_word;
         end
         if (in_beat.col == cell_index) begin
            col_in[in_beat.row] = load_word;
         end
      end
   end

   always_comb begin
      operand = $signed(in_beat.vec[cell_index]);
      for (int j = 0; j < mvt_pkg::LANES; j++) begin
         coef_sel[j] = in_beat.col_mode ? col_ff[j] : row_ff[j];
         prod_in[j]  = mvt_pkg::PROD_BITS'($signed(coef_sel[j]))
                     * mvt_pkg::PROD_BITS'(operand);
      end
   end

   always_comb begin
      b_beat_in = a_beat_ff;
      for (int j = 0; j < mvt_pkg::LANES; j++) begin
         prod_ext[j]       = mvt_pkg::SUM_BITS'(prod_ff[j]);
         b_beat_in.sums[j] = mvt_pkg::SUM_BITS'($signed(a_beat_ff.sums[j]) + prod_ext[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         row_ff     <= ident;
         col_ff     <= ident;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_beat_ff <= in_beat;
         prod_ff   <= prod_in;
      end
      if (b_ready) begin
         b_beat_ff <= b_beat_in;
      end
   end

endmodule

// File: rtl/mvt_sat.sv
module mvt_sat (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  mvt_pkg::beat_type in_beat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mvt_pkg::rsp_type  rsp_data
);

   logic                                   out_valid_ff;
   mvt_pkg::rsp_type                       out_data_ff, out_data_in;
   logic signed [mvt_pkg::SUM_BITS-1:0]    q [mvt_pkg::LANES];
   logic signed [mvt_pkg::WORD_BITS-1:0]   word [mvt_pkg::LANES];
   logic [mvt_pkg::LANES-1:0]              fits;

   assign in_ready  = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // floor shift, then clamp to the word range
   always_comb begin
      for (int j = 0; j < mvt_pkg::LANES; j++) begin
         q[j]    = $signed(in_beat.sums[j]) >>> mvt_pkg::FRAC_BITS;
         fits[j] = (&q[j][mvt_pkg::SUM_BITS-1:mvt_pkg::WORD_BITS-1])
                || !(|q[j][mvt_pkg::SUM_BITS-1:mvt_pkg::WORD_BITS-1]);
         if (fits[j]) begin
            word[j] = q[j][mvt_pkg::WORD_BITS-1:0];
         end else if (q[j][mvt_pkg::SUM_BITS-1]) begin
            word[j] = mvt_pkg::WORD_MIN;
         end else begin
            word[j] = mvt_pkg::WORD_MAX;
         end
      end
      out_data_in.res_x = mvt_pkg::PORT_BITS'(word[0]);
      out_data_in.res_y = mvt_pkg::PORT_BITS'(word[1]);
      out_data_in.res_z = mvt_pkg::PORT_BITS'(word[2]);
      out_data_in.res_w = in_beat.zero_w ? '0 : mvt_pkg::PORT_BITS'(word[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_ready) begin
         out_valid_ff <= in_valid && !in_beat.is_load;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

// File: rtl/matrix4_vector_transform.sv
// channel | ports                              | beat
// --------+------------------------------------+------------------------------------------
// request | req_valid, req_stall, req_data     | cmd, row/col index, vec_x..vec_w
// result  | rsp_valid, rsp_stall, rsp_data     | res_x..res_w, one per vector command
//
// one request beat per cycle unless a stalled result backs up the chain; a result passes through
// four cells of two stages each, then the shift and clamp output register
// loads travel the chain like vectors and update each cell as they pass, so order holds
// reset is synchronous: matrix back to identity, all stages empty, no clearing pass
// rsp_stall backs up stage by stage; empty stages still fill, so requests keep
// flowing until every stage holds a beat
module matrix4_vector_transform (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mvt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mvt_pkg::rsp_type rsp_data
);

   // chain taps: index 0 feeds the first cell, index LANES feeds the output stage
   logic              chain_valid [mvt_pkg::LANES+1];
   logic              chain_ready [mvt_pkg::LANES+1];
   mvt_pkg::beat_type chain_beat  [mvt_pkg::LANES+1];

   logic              cmd_legal;
   mvt_pkg::beat_type entry_beat;

   // unused command codes are taken and dropped at the door
   assign cmd_legal      = req_data.cmd <= mvt_pkg::CMD_DIR;
   assign chain_valid[0] = req_valid && cmd_legal;
   assign req_stall      = !chain_ready[0];

   // build the beat that enters the chain
   always_comb begin
      entry_beat.is_load  = req_data.cmd == mvt_pkg::CMD_LOAD;
      // matrix times column vector walks the columns held by the cells
      entry_beat.col_mode = req_data.cmd == mvt_pkg::CMD_MXV;
      entry_beat.zero_w   = (req_data.cmd == mvt_pkg::CMD_POS)
                         || (req_data.cmd == mvt_pkg::CMD_DIR);
      entry_beat.row      = req_data.row_index;
      entry_beat.col      = req_data.col_index;
      // each component is read from its low word bits, sign extended
      entry_beat.vec[0]   = mvt_pkg::VEC_BITS'($signed(req_data.vec_x[mvt_pkg::WORD_BITS-1:0]));
      entry_beat.vec[1]   = mvt_pkg::VEC_BITS'($signed(req_data.vec_y[mvt_pkg::WORD_BITS-1:0]));
      entry_beat.vec[2]   = mvt_pkg::VEC_BITS'($signed(req_data.vec_z[mvt_pkg::WORD_BITS-1:0]));
      case (req_data.cmd)
         mvt_pkg::CMD_POS: begin
            // implicit w of one brings in the translation row
            entry_beat.vec[3] = mvt_pkg::VEC_ONE;
         end
         mvt_pkg::CMD_DIR: begin
            entry_beat.vec[3] = '0;
         end
         default: begin
            entry_beat.vec[3] =
               mvt_pkg::VEC_BITS'($signed(req_data.vec_w[mvt_pkg::WORD_BITS-1:0]));
         end
      endcase
      // partial sums start from zero
      entry_beat.sums = '0;
   end

   assign chain_beat[0] = entry_beat;

   // cell k holds matrix row k and column k, and adds its four products
   // into the partial sums that pass by
   for (genvar g = 0; g < mvt_pkg::LANES; g++) begin : g_cell
      mvt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (mvt_pkg::IDX_BITS'(g)),
         .in_valid   (chain_valid[g]),
         .in_ready   (chain_ready[g]),
         .in_beat    (chain_beat[g]),
         .out_valid  (chain_valid[g+1]),
         .out_ready  (chain_ready[g+1]),
         .out_beat   (chain_beat[g+1])
      );
   end

   // shift, clamp, drop load beats, hold the result for the consumer
   mvt_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[mvt_pkg::LANES]),
      .in_ready  (chain_ready[mvt_pkg::LANES]),
      .in_beat   (chain_beat[mvt_pkg::LANES]),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/mvt_checker.sv
`include "matrix4_vector_transform_assert.svh"

module mvt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mvt_pkg::rsp_type rsp_data
);

   // a waiting result stays up
   `MVT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result beat dropped while stalled")

   // and keeps its value
   `MVT_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_data), "stalled result changed")

   // nothing comes out right after reset
   `MVT_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid, "result beat right after reset")

   // unless the consumer holds a result back, the chain always has room
   `MVT_ASSERT_NOW(a_no_false_stall, !(rsp_valid && rsp_stall), !req_stall, "request stalled with free output")

endmodule

bind matrix4_vector_transform mvt_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: verif/tb_matrix4_vector_transform.sv
module tb_matrix4_vector_transform;
   timeunit 1ns;
   timeprecision 1ps;

   import mvt_pkg::*;

   // spare command codes, the block drops them without a result
   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

   // handy q16.16 words
   localparam logic [31:0] TOP_WORD    = 32'h7FFF_FFFF;
   localparam logic [31:0] BOTTOM_WORD = 32'h8000_0000;
   localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
   localparam logic [31:0] HALF_Q16    = 32'h0000_8000;

   // signed range of a stored word, held wide enough for any dot product
   localparam logic signed [95:0] WORD_HI = (96'sd1 <<< (WORD_BITS - 1)) - 96'sd1;
   localparam logic signed [95:0] WORD_LO = -WORD_HI - 96'sd1;
   // identity diagonal: 1.0, clamped when the word is too narrow to hold it
   localparam logic signed [WORD_BITS-1:0] COEF_UNIT =
      (WORD_BITS > 17) ? WORD_BITS'(65536) : WORD_HI[WORD_BITS-1:0];

   // drain allowance for the chain, with slack
   localparam int DRAIN_CYCLES = 20;

   logic    clock;
   logic    reset      = 1'b1;
   logic    req_valid  = 1'b0;
   logic    req_stall;
   req_type req_data   = '0;
   logic    rsp_valid;
   logic    rsp_stall  = 1'b0;
   rsp_type rsp_data;

   // shadow copy of the coefficient matrix, row-major
   logic signed [WORD_BITS-1:0] coef_matrix [16];
   // transformed vectors still to come out, oldest first
   rsp_type transformed_vectors [$];
   rsp_type oldest_vector;
   int      mismatch_count = 0;

   // knobs shared by the stimulus and the result side
   bit sender_gaps_on     = 1'b1;
   bit receiver_stalls_on = 1'b1;
   int result_hold_cycles = 0;

   matrix4_vector_transform uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // matrix and transform predictor
   // ------------------------------------------------------------------

   function automatic void load_identity();
      for (int i = 0; i < 16; i++) begin
         coef_matrix[i] = (i % 5 == 0) ? COEF_UNIT : '0;
      end
   endfunction

   // port word read from its low WORD_BITS bits, sign-extended
   function automatic logic signed [95:0] port_word(input logic [31:0] raw);
      logic signed [WORD_BITS-1:0] low;
      low = raw[WORD_BITS-1:0];
      return 96'(low);
   endfunction

   function automatic logic [31:0] clamp_word(input logic signed [95:0] value);
      if (value > WORD_HI) begin
         return WORD_HI[31:0];
      end
      if (value < WORD_LO) begin
         return WORD_LO[31:0];
      end
      return value[31:0];
   endfunction

   // applies one accepted beat to the shadow matrix; returns 1 with the
   // transformed vector when the beat produces one
   function automatic bit transform_vector(input req_type item, output rsp_type vec_out);
      logic signed [95:0] vec [4];
      logic signed [95:0] coef;
      logic signed [95:0] acc;
      logic [31:0]        lanes [4];
      vec_out = '0;
      vec[0] = port_word(item.vec_x);
      vec[1] = port_word(item.vec_y);
      vec[2] = port_word(item.vec_z);
      vec[3] = port_word(item.vec_w);
      case (item.cmd)
         CMD_LOAD: begin
            coef_matrix[{item.row_index, item.col_index}] = item.vec_x[WORD_BITS-1:0];
            return 1'b0;
         end
         CMD_VXM, CMD_MXV: begin
         end
         CMD_POS: begin
            vec[3] = 96'sd65536;
         end
         CMD_DIR: begin
            vec[3] = '0;
         end
         default: begin
            return 1'b0;
         end
      endcase
      for (int lane = 0; lane < 4; lane++) begin
         acc = '0;
         for (int k = 0; k < 4; k++) begin
            // column vector mode walks a row, the others walk a column
            coef = 96'((item.cmd == CMD_MXV) ? coef_matrix[lane * 4 + k]
                                             : coef_matrix[k * 4 + lane]);
            acc += coef * vec[k];
         end
         lanes[lane] = clamp_word(acc >>> FRAC_BITS);
      end
      vec_out.res_x = lanes[0];
      vec_out.res_y = lanes[1];
      vec_out.res_z = lanes[2];
      vec_out.res_w = (item.cmd == CMD_POS || item.cmd == CMD_DIR) ? '0 : lanes[3];
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic req_type make_request(input logic [2:0] cmd, input logic [1:0] row,
                                            input logic [1:0] col, input logic [31:0] x,
                                            input logic [31:0] y, input logic [31:0] z,
                                            input logic [31:0] w);
      req_type item;
      item.cmd       = cmd;
      item.row_index = row;
      item.col_index = col;
      item.vec_x     = x;
      item.vec_y     = y;
      item.vec_z     = z;
      item.vec_w     = w;
      return item;
   endfunction

   // mix of range ends, unit values, modest q16.16 numbers and raw noise
   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 9))
         0: return TOP_WORD;
         1: return BOTTOM_WORD;
         2: return '0;
         3: return ($urandom_range(0, 1) != 0) ? ONE_Q16 : -ONE_Q16;
         4, 5, 6: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_request(input bit vectors_only);
      req_type item;
      int      pick;
      pick = vectors_only ? $urandom_range(25, 92) : $urandom_range(0, 99);
      if (pick < 25) begin
         item.cmd = CMD_LOAD;
      end else if (pick < 42) begin
         item.cmd = CMD_VXM;
      end else if (pick < 59) begin
         item.cmd = CMD_MXV;
      end else if (pick < 76) begin
         item.cmd = CMD_POS;
      end else if (pick < 93) begin
         item.cmd = CMD_DIR;
      end else begin
         item.cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      end
      item.row_index = 2'($urandom_range(0, 3));
      item.col_index = 2'($urandom_range(0, 3));
      item.vec_x     = random_word();
      item.vec_y     = random_word();
      item.vec_z     = random_word();
      item.vec_w     = random_word();
      return item;
   endfunction

   // idle run length: mostly short, now and then long
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         return $urandom_range(1, 3);
      end else if (pick < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // offer one beat, hold it until taken, then predict its result
   task automatic send_request(input req_type item);
      rsp_type vec_out;
      int      gap;
      gap = (sender_gaps_on && $urandom_range(0, 1) != 0) ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         // junk on the bus while idle, must be ignored
         req_data  <= random_request(1'b0);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (transform_vector(item, vec_out)) begin
         transformed_vectors.push_back(vec_out);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (transformed_vectors.size() != 0) @(posedge clock);
      // loads leave no result, let the chain empty behind the last one
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------

   // random stall runs, or one long hold when a test asks for it
   initial begin
      int run_left;
      bit run_stall;
      run_left  = 0;
      run_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (result_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            result_hold_cycles--;
         end else begin
            if (run_left == 0) begin
               run_stall = receiver_stalls_on && ($urandom_range(0, 2) == 0);
               run_left  = idle_length();
            end
            run_left--;
            rsp_stall <= run_stall;
         end
      end
   end

   task automatic compare_lane(input string lane, input logic [31:0] want,
                               input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, lane, want, got);
         mismatch_count++;
      end
   endtask

   // every result beat is matched against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (transformed_vectors.size() == 0) begin
            $display("%0t: unexpected result beat, expected none actual %h",
                     $time, rsp_data);
            mismatch_count++;
         end else begin
            oldest_vector = transformed_vectors.pop_front();
            compare_lane("res_x", oldest_vector.res_x, rsp_data.res_x);
            compare_lane("res_y", oldest_vector.res_y, rsp_data.res_y);
            compare_lane("res_z", oldest_vector.res_z, rsp_data.res_z);
            compare_lane("res_w", oldest_vector.res_w, rsp_data.res_w);
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // identity after reset: every mode passes the vector through, w ignored
   // by position and direction, spare commands leave the matrix alone
   task automatic test_identity_matrix();
      send_request(make_request(CMD_VXM, 2'd0, 2'd0, TOP_WORD, BOTTOM_WORD, '0, -32'd1));
      send_request(make_request(CMD_MXV, 2'd3, 2'd3, 32'd1, -ONE_Q16, TOP_WORD,
                                BOTTOM_WORD));
      send_request(make_request(CMD_POS, 2'd1, 2'd2, BOTTOM_WORD, TOP_WORD, ONE_Q16,
                                TOP_WORD));
      send_request(make_request(CMD_DIR, 2'd2, 2'd1, -32'd1, 32'd1, BOTTOM_WORD,
                                BOTTOM_WORD));
      // spare codes that would clear the corner if taken as loads
      for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
         send_request(make_request(3'(c), 2'd3, 2'd3, '0, '0, '0, '0));
      end
      send_request(make_request(CMD_VXM, 2'd0, 2'd0, ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16));
      wait_drained();
   endtask

   // extreme coefficients: saturation at both ends, floor on negative
   // fractions, translation row in position mode but not in direction mode
   task automatic test_load_extremes();
      send_request(make_request(CMD_LOAD, 2'd0, 2'd0, TOP_WORD, '0, '0, '0));
      send_request(make_request(CMD_LOAD, 2'd1, 2'd0, TOP_WORD, '0, '0, '0));
      send_request(make_request(CMD_LOAD, 2'd3, 2'd0, BOTTOM_WORD, '0, '0, '0));
      send_request(make_request(CMD_LOAD, 2'd0, 2'd3, BOTTOM_WORD, '0, '0, '0));
      send_request(make_request(CMD_LOAD, 2'd3, 2'd3, -32'd1, '0, '0, '0));
      send_request(make_request(CMD_LOAD, 2'd2, 2'd1, HALF_Q16, '0, '0, '0));
      send_request(make_request(CMD_LOAD, 2'd3, 2'd1, 3 * ONE_Q16, '0, '0, '0));
      send_request(make_request(CMD_VXM, 2'd0, 2'd0, TOP_WORD, TOP_WORD, '0, TOP_WORD));
      send_request(make_request(CMD_VXM, 2'd0, 2'd0, BOTTOM_WORD, BOTTOM_WORD, -32'd1,
                                '0));
      send_request(make_request(CMD_VXM, 2'd0, 2'd0, -32'd1, '0, '0, '0));
      send_request(make_request(CMD_MXV, 2'd0, 2'd0, TOP_WORD, BOTTOM_WORD, -32'd1,
                                32'd1));
      send_request(make_request(CMD_POS, 2'd0, 2'd0, ONE_Q16, -32'd3, BOTTOM_WORD, '0));
      send_request(make_request(CMD_DIR, 2'd0, 2'd0, ONE_Q16, -32'd3, BOTTOM_WORD, '0));
      wait_drained();
   endtask

   // back to back beats, no stalls on either side
   task automatic test_full_rate();
      sender_gaps_on     = 1'b0;
      receiver_stalls_on = 1'b0;
      repeat (200) send_request(random_request(1'b0));
      sender_gaps_on     = 1'b1;
      receiver_stalls_on = 1'b1;
      wait_drained();
   endtask

   // long random mix of loads, transforms and spare codes with idling
   task automatic test_random_traffic();
      repeat (1100) send_request(random_request(1'b0));
      wait_drained();
   endtask

   // result side holds off while beats keep coming, chain fills and
   // pushes back on the request side
   task automatic test_output_hold();
      sender_gaps_on     = 1'b0;
      result_hold_cycles = 80;
      repeat (40) send_request(random_request(1'b1));
      sender_gaps_on     = 1'b1;
      wait_drained();
   endtask

   // sender stops until every result is home, then resumes
   task automatic test_sender_pause();
      repeat (30) send_request(random_request(1'b0));
      wait_drained();
      repeat (30) send_request(random_request(1'b0));
      wait_drained();
   endtask

   initial begin
      load_identity();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_identity_matrix();
      test_load_extremes();
      test_full_rate();
      test_random_traffic();
      test_output_hold();
      test_sender_pause();

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/mvt_pkg.sv
rtl/mvt_cell.sv
rtl/mvt_sat.sv
rtl/matrix4_vector_transform.sv
rtl/mvt_checker.sv
verif/tb_matrix4_vector_transform.sv
